### rtl/msrg_pkg.sv
// Shared constants and types for the motor speed ramp generator.
// Has no dependencies; every other file of the block imports it.
`timescale 1ns / 1ps

package msrg_pkg;

   // Width of the goal and present speed registers.
   localparam int SPEED_BITS = 20;
   // Width of the speed carried in one frame.
   localparam int FRAME_BITS = 20;
   // Width of the commanded speed field.
   localparam int TARGET_BITS = 32;
   // A 16-bit clamped speed times a 4-bit pole count.
   localparam int PROD_BITS = 20;
   // Common width for the saturation compare.
   localparam int CMP_BITS = (SPEED_BITS > PROD_BITS) ? SPEED_BITS : PROD_BITS;

   // Configuration port geometry.
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS = 16;

   // Register indexes.
   localparam logic [CSR_INDEX_BITS-1:0] REG_MAX_SPEED   = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_POLE_COUNT  = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_STEP_SIZE   = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_SEND_PERIOD = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] REG_START_DELAY = 3'd4;

   // Register values after reset.
   localparam logic [15:0] RST_MAX_SPEED   = 16'd3000;
   localparam logic [3:0]  RST_POLE_COUNT  = 4'd7;
   localparam logic [15:0] RST_STEP_SIZE   = 16'd35;
   localparam logic [7:0]  RST_SEND_PERIOD = 8'd10;
   localparam logic [3:0]  RST_START_DELAY = 4'd1;

   // Item codes.
   localparam logic CMD_TICK  = 1'b0;
   localparam logic CMD_SPEED = 1'b1;

   typedef struct packed {
      logic [15:0] max_speed;
      logic [3:0]  pole_count;
      logic [15:0] step_size;
      logic [7:0]  send_period;
      logic [3:0]  start_delay;
   } msrg_cfg_type;

   typedef struct packed {
      logic                          command;
      logic signed [TARGET_BITS-1:0] target_speed;
   } msrg_item_type;

endpackage

### rtl/msrg_req_if.sv
// Request channel interface: ticks and speed commands.
// Depends on msrg_pkg for the field widths.
`timescale 1ns / 1ps

interface msrg_req_if;
   import msrg_pkg::*;

   logic                          valid;
   logic                          ready;
   logic                          command;
   logic signed [TARGET_BITS-1:0] target_speed;

   modport source (output valid, output command, output target_speed, input ready);
   modport sink (input valid, input command, input target_speed, output ready);
endinterface

### rtl/msrg_rsp_if.sv
// Response channel interface: one emitted speed frame per beat.
// Depends on msrg_pkg for the field width.
`timescale 1ns / 1ps

interface msrg_rsp_if;
   import msrg_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [FRAME_BITS-1:0] frame_speed;

   modport source (output valid, output frame_speed, input ready);
   modport sink (input valid, input frame_speed, output ready);
endinterface

### rtl/msrg_csr_regs.sv
// Configuration register bank of the ramp generator.
// Depends on msrg_pkg for indexes, reset values and the config struct.
`timescale 1ns / 1ps

module msrg_csr_regs (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_write_en,
   input  logic [msrg_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [msrg_pkg::CSR_DATA_BITS-1:0]     csr_write_data,
   output msrg_pkg::msrg_cfg_type                 cfg
);
   import msrg_pkg::*;

   msrg_cfg_type cfg_ff;
   msrg_cfg_type cfg_in;

   // Decode a write into the addressed field; unknown indexes are dropped.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            REG_MAX_SPEED:   cfg_in.max_speed   = csr_write_data;
            REG_POLE_COUNT:  cfg_in.pole_count  = csr_write_data[3:0];
            REG_STEP_SIZE:   cfg_in.step_size   = csr_write_data;
            REG_SEND_PERIOD: cfg_in.send_period = csr_write_data[7:0];
            REG_START_DELAY: cfg_in.start_delay = csr_write_data[3:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_speed   <= RST_MAX_SPEED;
         cfg_ff.pole_count  <= RST_POLE_COUNT;
         cfg_ff.step_size   <= RST_STEP_SIZE;
         cfg_ff.send_period <= RST_SEND_PERIOD;
         cfg_ff.start_delay <= RST_START_DELAY;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;
endmodule

### rtl/msrg_in_stage.sv
// Input register that holds one request beat until the ramp logic takes it.
// Depends on msrg_pkg for the item struct.
`timescale 1ns / 1ps

module msrg_in_stage (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  msrg_pkg::msrg_item_type req_item,
   input  logic                    advance,
   output logic                    item_valid,
   output msrg_pkg::msrg_item_type item
);
   import msrg_pkg::*;

   logic          valid_ff;
   logic          valid_in;
   msrg_item_type item_ff;

   // The register takes a new beat when empty or when its content moves on.
   assign req_ready = !valid_ff || advance;

   always_comb begin
      valid_in = valid_ff;
      if (advance) begin
         valid_in = 1'b0;
      end
      if (req_valid && req_ready) begin
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload needs no reset.
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_ff <= req_item;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;
endmodule

### rtl/msrg_ramp_unit.sv
// Ramp state and its update logic: goal, present speed, divider, delay.
// Depends on msrg_pkg for widths, codes and the config and item structs.
`timescale 1ns / 1ps

module msrg_ramp_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                step_en,
   input  msrg_pkg::msrg_item_type             item,
   input  msrg_pkg::msrg_cfg_type              cfg,
   output logic                                emit,
   output logic [msrg_pkg::FRAME_BITS-1:0]     frame_speed
);
   import msrg_pkg::*;

   localparam logic [SPEED_BITS-1:0] SPD_MAX = '1;

   logic [SPEED_BITS-1:0] goal_ff, goal_in;
   logic [SPEED_BITS-1:0] present_ff, present_in;
   logic                  running_ff, running_in;
   logic [7:0]            div_ff, div_in;
   logic [3:0]            delay_ff, delay_in;

   logic [15:0]           clamped;
   logic [PROD_BITS-1:0]  product;
   logic [SPEED_BITS-1:0] goal_cmd;
   logic [7:0]            next_div;
   logic [7:0]            period;
   logic                  hold;
   logic                  delay_done;
   logic [SPEED_BITS-1:0] step_ext;
   logic [SPEED_BITS-1:0] diff_up;
   logic [SPEED_BITS-1:0] diff_down;
   logic [SPEED_BITS-1:0] approached;

   // Clamp the command to 0..max_speed and scale by the pole count.
   always_comb begin
      if (item.target_speed[TARGET_BITS-1]) begin
         clamped = '0;
      end else if (TARGET_BITS'(unsigned'(item.target_speed)) >
                   TARGET_BITS'(cfg.max_speed)) begin
         clamped = cfg.max_speed;
      end else begin
         clamped = item.target_speed[15:0];
      end
   end

   assign product  = PROD_BITS'(clamped) * PROD_BITS'(cfg.pole_count);
   assign goal_cmd = (CMP_BITS'(product) > CMP_BITS'(SPD_MAX)) ? SPD_MAX
                                                             : SPEED_BITS'(product);

   // Tick divider: a frame goes out when the count wraps or reaches the period.
   assign next_div   = div_ff + 8'd1;
   assign period     = (cfg.send_period == 8'd0) ? 8'd1 : cfg.send_period;
   assign hold       = (next_div < period) && (next_div != 8'd0);
   assign delay_done = delay_ff >= cfg.start_delay;

   // Move the present speed toward the goal by at most one step.
   assign step_ext  = SPEED_BITS'(cfg.step_size);
   assign diff_up   = goal_ff - present_ff;
   assign diff_down = present_ff - goal_ff;

   always_comb begin
      if (present_ff < goal_ff) begin
         approached = (diff_up <= step_ext) ? goal_ff : present_ff + step_ext;
      end else if (present_ff > goal_ff) begin
         approached = (diff_down <= step_ext) ? goal_ff : present_ff - step_ext;
      end else begin
         approached = present_ff;
      end
   end

   // Next state for the beat being processed.
   always_comb begin
      goal_in    = goal_ff;
      present_in = present_ff;
      running_in = running_ff;
      div_in     = div_ff;
      delay_in   = delay_ff;
      if (step_en) begin
         if (item.command == CMD_SPEED) begin
            goal_in    = goal_cmd;
            running_in = 1'b1;
            delay_in   = 4'd0;
         end else if (running_ff) begin
            if (hold) begin
               div_in = next_div;
            end else begin
               div_in = 8'd0;
               if (delay_done) begin
                  delay_in   = cfg.start_delay;
                  present_in = approached;
               end else begin
                  delay_in = delay_ff + 4'd1;
               end
               if ((present_in == '0) && (goal_ff == '0)) begin
                  running_in = 1'b0;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         goal_ff    <= '0;
         present_ff <= '0;
         running_ff <= 1'b0;
         div_ff     <= 8'd0;
         delay_ff   <= 4'd0;
      end else begin
         goal_ff    <= goal_in;
         present_ff <= present_in;
         running_ff <= running_in;
         div_ff     <= div_in;
         delay_ff   <= delay_in;
      end
   end

   assign emit = step_en && (item.command == CMD_TICK) && running_ff && !hold;
   assign frame_speed = FRAME_BITS'(present_in);
endmodule

### rtl/msrg_out_stage.sv
// Result register that holds one frame until the response side takes it.
// Depends on msrg_pkg for the frame width.
`timescale 1ns / 1ps

module msrg_out_stage (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            load,
   input  logic [msrg_pkg::FRAME_BITS-1:0] frame_in,
   output logic                            out_free,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [msrg_pkg::FRAME_BITS-1:0] rsp_frame_speed
);
   import msrg_pkg::*;

   logic                  valid_ff;
   logic                  valid_in;
   logic [FRAME_BITS-1:0] frame_ff;

   // The register can take a frame this cycle if it is empty or being drained.
   assign out_free = !valid_ff || rsp_ready;

   always_comb begin
      valid_in = valid_ff;
      if (rsp_ready) begin
         valid_in = 1'b0;
      end
      if (load) begin
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         frame_ff <= frame_in;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_frame_speed = frame_ff;
endmodule

### rtl/motor_speed_ramp_generator_core.sv
// A tick that emits passes through the input register and then the result register
// before its frame shows on rsp, and waits longer only while rsp stalls.
// Throughput: one beat per cycle, ticks and commands alike, while rsp keeps up;
// the input register and the result register each hold one beat, and the ramp
// state is updated as a beat moves from the one into the other.
// Reset (synchronous, active high) clears the ramp state, empties both registers
// and loads the configuration defaults; req is ready in the first cycle after it.
`timescale 1ns / 1ps

module motor_speed_ramp_generator_core (
   input  logic                                clock,
   input  logic                                reset,
   msrg_req_if.sink                            req_chan,
   msrg_rsp_if.source                          rsp_chan,
   input  logic                                csr_write_en,
   input  logic [msrg_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [msrg_pkg::CSR_DATA_BITS-1:0]  csr_write_data
);
   import msrg_pkg::*;

   msrg_cfg_type          cfg;
   msrg_item_type         req_item;
   msrg_item_type         item;
   logic                  item_valid;
   logic                  out_free;
   logic                  advance;
   logic                  emit;
   logic [FRAME_BITS-1:0] frame_speed;

   assign req_item.command      = req_chan.command;
   assign req_item.target_speed = req_chan.target_speed;

   // A held beat moves on whenever the result register could take its frame.
   assign advance = item_valid && out_free;

   msrg_csr_regs u_csr_regs (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data),
      .cfg            (cfg)
   );

   msrg_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_chan.valid),
      .req_ready  (req_chan.ready),
      .req_item   (req_item),
      .advance    (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   msrg_ramp_unit u_ramp_unit (
      .clock       (clock),
      .reset       (reset),
      .step_en     (advance),
      .item        (item),
      .cfg         (cfg),
      .emit        (emit),
      .frame_speed (frame_speed)
   );

   msrg_out_stage u_out_stage (
      .clock           (clock),
      .reset           (reset),
      .load            (emit),
      .frame_in        (frame_speed),
      .out_free        (out_free),
      .rsp_valid       (rsp_chan.valid),
      .rsp_ready       (rsp_chan.ready),
      .rsp_frame_speed (rsp_chan.frame_speed)
   );
endmodule

### rtl/msrg_checker.sv
// Port-level checks for the ramp generator, bound to the top level.
// Depends on msrg_pkg for widths and register indexes.
`timescale 1ns / 1ps

module msrg_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_ready,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic [msrg_pkg::FRAME_BITS-1:0]     rsp_frame_speed,
   input logic                                csr_write_en,
   input logic [msrg_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input logic [msrg_pkg::CSR_DATA_BITS-1:0]  csr_write_data
);
   import msrg_pkg::*;

   logic [15:0]           step_ff;
   logic [FRAME_BITS-1:0] last_frame_ff;
   logic [FRAME_BITS-1:0] delta;

   // Shadow of the step size and of the last delivered frame.
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff       <= RST_STEP_SIZE;
         last_frame_ff <= '0;
      end else begin
         if (csr_write_en && (csr_index == REG_STEP_SIZE)) begin
            step_ff <= csr_write_data;
         end
         if (rsp_valid && rsp_ready) begin
            last_frame_ff <= rsp_frame_speed;
         end
      end
   end

   assign delta = (rsp_frame_speed >= last_frame_ff) ? rsp_frame_speed - last_frame_ff
                                                     : last_frame_ff - rsp_frame_speed;

   // A stalled frame stays on the port unchanged.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_frame_speed))
      else $error("frame changed or vanished while stalled");

   // Reset empties the result register.
   a_rsp_reset: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("frame offered right after reset");

   // Reset empties the input register, so a beat can be taken at once.
   a_req_reset: assert property (@(posedge clock) reset |=> req_ready)
      else $error("request side not ready after reset");

   // Successive frames never move by more than one step.
   a_slew: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready |-> delta <= FRAME_BITS'(step_ff))
      else $error("speed changed by more than the step size between frames");

   // An accepted beat never leaves the ready line at an unknown level.
   a_req_known: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !$isunknown(req_ready))
      else $error("request ready unknown after an accepted beat");
endmodule

bind motor_speed_ramp_generator_core msrg_checker u_msrg_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_chan.valid),
   .req_ready       (req_chan.ready),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_frame_speed (rsp_chan.frame_speed),
   .csr_write_en    (csr_write_en),
   .csr_index       (csr_index),
   .csr_write_data  (csr_write_data)
);

### tb/tb.sv
// Self-checking testbench for motor_speed_ramp_generator_core: drives ticks and speed
// commands, predicts every emitted frame and checks it beat by beat.
// Depends on msrg_pkg, msrg_req_if, msrg_rsp_if and the core itself.
`timescale 1ns / 1ps

module tb;
   import msrg_pkg::*;

   logic                      clock;
   logic                      reset;
   logic                      csr_write_en;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0]  csr_write_data;

   msrg_req_if req_if();
   msrg_rsp_if rsp_if();

   motor_speed_ramp_generator_core dut (
      .clock          (clock),
      .reset          (reset),
      .req_chan       (req_if),
      .rsp_chan       (rsp_if),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data)
   );

   // Beats waiting to be sent and frames waiting to be seen.
   msrg_item_type         beat_queue[$];
   logic [FRAME_BITS-1:0] frame_expect[$];

   // Shadow of the configuration and of the ramp state.
   msrg_cfg_type          ramp_cfg;
   logic [SPEED_BITS-1:0] goal_spd;
   logic [SPEED_BITS-1:0] cur_spd;
   logic                  is_running;
   logic [7:0]            div_count;
   logic [3:0]            hold_count;

   int fail_count = 0;
   int req_gap = 0;
   int rsp_hold = 0;
   bit steady = 1'b0;

   // Clock generation.
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Move one speed toward another by at most one step.
   function automatic logic [SPEED_BITS-1:0] slew_toward(input logic [SPEED_BITS-1:0] from,
                                                         input logic [SPEED_BITS-1:0] to,
                                                         input logic [15:0] step);
      if (from < to) return ((to - from) <= step) ? to : from + step;
      if (from > to) return ((from - to) <= step) ? to : from - step;
      return from;
   endfunction

   // Update the shadow ramp state for one accepted beat and queue any frame it causes.
   task automatic ramp_advance(input logic cmd, input logic [TARGET_BITS-1:0] tgt);
      logic [15:0] clamped;
      logic [63:0] prod;
      logic [63:0] spd_max;
      logic [7:0]  nxt;
      logic [7:0]  period;
      spd_max = (64'd1 << SPEED_BITS) - 64'd1;
      if (cmd == CMD_SPEED) begin
         if (tgt[TARGET_BITS-1]) clamped = 16'd0;
         else if (tgt[TARGET_BITS-2:0] > {{(TARGET_BITS-17){1'b0}}, ramp_cfg.max_speed})
            clamped = ramp_cfg.max_speed;
         else clamped = tgt[15:0];
         prod = 64'(clamped) * 64'(ramp_cfg.pole_count);
         goal_spd = (prod > spd_max) ? '1 : prod[SPEED_BITS-1:0];
         is_running = 1'b1;
         hold_count = 4'd0;
         return;
      end
      if (!is_running) return;
      nxt = div_count + 8'd1;
      period = (ramp_cfg.send_period == 8'd0) ? 8'd1 : ramp_cfg.send_period;
      if (nxt < period && nxt != 8'd0) begin
         div_count = nxt;
         return;
      end
      div_count = 8'd0;
      // Ramping waits out the start delay, counted in frames.
      if (hold_count >= ramp_cfg.start_delay) begin
         hold_count = ramp_cfg.start_delay;
         cur_spd = slew_toward(cur_spd, goal_spd, ramp_cfg.step_size);
      end else begin
         hold_count = hold_count + 4'd1;
      end
      frame_expect.push_back(FRAME_BITS'(cur_spd));
      if (cur_spd == '0 && goal_spd == '0) is_running = 1'b0;
   endtask

   // Idle cycles before the next beat on either side.
   function automatic int idle_draw();
      if (steady || $urandom_range(0, 3) == 0) return 0;
      return $urandom_range(0, 13);
   endfunction

   // Request driver: one beat per handshake, with random gaps.
   always @(posedge clock) begin : req_driver
      msrg_item_type item;
      if (reset) begin
         req_if.valid <= 1'b0;
         req_gap = 0;
      end else begin
         if (req_if.valid && req_if.ready) ramp_advance(req_if.command, req_if.target_speed);
         if (!req_if.valid || req_if.ready) begin
            if (beat_queue.size() == 0) begin
               req_if.valid <= 1'b0;
            end else if (req_gap > 0) begin
               req_gap--;
               req_if.valid <= 1'b0;
            end else begin
               item = beat_queue.pop_front();
               req_if.command <= item.command;
               req_if.target_speed <= item.target_speed;
               req_if.valid <= 1'b1;
               req_gap = idle_draw();
            end
         end
      end
   end

   // Frame monitor: compares each accepted frame with the oldest prediction.
   always @(posedge clock) begin : rsp_monitor
      logic [FRAME_BITS-1:0] want;
      if (reset) begin
         rsp_if.ready <= 1'b0;
         rsp_hold = 0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (frame_expect.size() == 0) begin
               $display("%0t unexpected frame: expected none, actual frame_speed %0d",
                        $time, rsp_if.frame_speed);
               fail_count++;
            end else begin
               want = frame_expect.pop_front();
               if (rsp_if.frame_speed !== want) begin
                  $display("%0t frame_speed mismatch: expected %0d, actual %0d",
                           $time, want, rsp_if.frame_speed);
                  fail_count++;
               end
            end
            rsp_hold = idle_draw();
         end else if (rsp_hold > 0) begin
            rsp_hold--;
         end
         rsp_if.ready <= (rsp_hold == 0);
      end
   end

   // Write one register and mirror it in the shadow configuration.
   task automatic write_reg(input logic [CSR_INDEX_BITS-1:0] idx, input logic [15:0] value);
      @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_en <= 1'b0;
      case (idx)
         REG_MAX_SPEED:   ramp_cfg.max_speed = value;
         REG_POLE_COUNT:  ramp_cfg.pole_count = value[3:0];
         REG_STEP_SIZE:   ramp_cfg.step_size = value;
         REG_SEND_PERIOD: ramp_cfg.send_period = value[7:0];
         REG_START_DELAY: ramp_cfg.start_delay = value[3:0];
         default: ;
      endcase
   endtask

   task automatic write_all(input logic [15:0] max_spd, input logic [3:0] poles,
                            input logic [15:0] step, input logic [7:0] period,
                            input logic [3:0] delay);
      write_reg(REG_MAX_SPEED, max_spd);
      write_reg(REG_POLE_COUNT, {12'd0, poles});
      write_reg(REG_STEP_SIZE, step);
      write_reg(REG_SEND_PERIOD, {8'd0, period});
      write_reg(REG_START_DELAY, {12'd0, delay});
   endtask

   task automatic queue_beat(input logic cmd, input logic [TARGET_BITS-1:0] tgt);
      msrg_item_type item;
      item.command = cmd;
      item.target_speed = tgt;
      beat_queue.push_back(item);
   endtask

   // Commanded speed: mostly near the clamp range, sometimes negative or extreme.
   function automatic logic [TARGET_BITS-1:0] pick_target();
      case ($urandom_range(0, 7))
         0: return $urandom;
         1: return $urandom | 32'h8000_0000;
         2: return 32'd0;
         3: return 32'h7FFF_FFFF;
         default: return $urandom_range(0, int'(ramp_cfg.max_speed) + 100);
      endcase
   endfunction

   // Mostly ticks with an occasional new command; ticks carry junk payload.
   task automatic fill_random(input int count);
      if ($urandom_range(0, 1) == 0) queue_beat(CMD_SPEED, pick_target());
      repeat (count) begin
         if ($urandom_range(0, 7) == 0) queue_beat(CMD_SPEED, pick_target());
         else queue_beat(CMD_TICK, $urandom);
      end
   endtask

   // Wait until every beat is sent and every frame seen, then let the pipe empty.
   task automatic drain();
      @(negedge clock);
      while (beat_queue.size() != 0 || req_if.valid || frame_expect.size() != 0)
         @(negedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Main sequence.
   initial begin
      reset = 1'b1;
      csr_write_en = 1'b0;
      csr_index = '0;
      csr_write_data = '0;
      req_if.valid = 1'b0;
      req_if.command = CMD_TICK;
      req_if.target_speed = '0;
      rsp_if.ready = 1'b0;
      ramp_cfg.max_speed = RST_MAX_SPEED;
      ramp_cfg.pole_count = RST_POLE_COUNT;
      ramp_cfg.step_size = RST_STEP_SIZE;
      ramp_cfg.send_period = RST_SEND_PERIOD;
      ramp_cfg.start_delay = RST_START_DELAY;
      goal_spd = '0;
      cur_spd = '0;
      is_running = 1'b0;
      div_count = '0;
      hold_count = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Reset configuration first.
      @(negedge clock);
      fill_random(20);
      drain();

      // Directed: widest clamp and step, every tick emits, no start delay.
      write_all(16'hFFFF, 4'd15, 16'hFFFF, 8'd1, 4'd0);
      @(negedge clock);
      steady = 1'b1;
      queue_beat(CMD_TICK, 32'd0);
      queue_beat(CMD_SPEED, 32'h7FFF_FFFF);
      repeat (15) queue_beat(CMD_TICK, 32'hFFFF_FFFF);
      queue_beat(CMD_SPEED, 32'h8000_0000);
      queue_beat(CMD_TICK, 32'd0);
      queue_beat(CMD_SPEED, 32'hFFFF_FFFF);
      queue_beat(CMD_TICK, 32'd0);
      queue_beat(CMD_SPEED, 32'd0);
      queue_beat(CMD_TICK, 32'd0);
      drain();
      steady = 1'b0;

      // Zero clamp, zero poles, zero step, zero period, longest start delay.
      write_all(16'd0, 4'd0, 16'd0, 8'd0, 4'd15);
      @(negedge clock);
      fill_random(20);
      drain();

      // Longest period; the divider is left high for the next phase.
      write_all(16'd40000, 4'd15, 16'($urandom_range(1, 65535)), 8'd255, 4'd0);
      @(negedge clock);
      queue_beat(CMD_SPEED, 32'd3000);
      repeat (260) queue_beat(CMD_TICK, $urandom);
      drain();

      // Lowering the period below the divider makes the next tick emit at once.
      write_reg(REG_SEND_PERIOD, 16'd2);
      @(negedge clock);
      queue_beat(CMD_TICK, $urandom);
      fill_random(20);
      drain();

      // Random settings, leaning toward short periods so frames come often.
      repeat (4) begin
         write_all(($urandom_range(0, 3) == 0) ? 16'hFFFF :
                   ($urandom_range(0, 2) == 0) ? 16'($urandom_range(0, 65535)) :
                                                 16'($urandom_range(50, 5000)),
                   4'($urandom_range(0, 15)),
                   ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 65535)) :
                                                 16'($urandom_range(1, 2000)),
                   ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 20)) :
                                                 8'($urandom_range(1, 4)),
                   ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15)) :
                                                 4'($urandom_range(0, 3)));
         steady = ($urandom_range(0, 3) == 0);
         @(negedge clock);
         fill_random(20);
         drain();
      end

      repeat (8) @(posedge clock);
      if (fail_count == 0 && frame_expect.size() == 0) begin
         $display("PASS motor_speed_ramp_generator_core");
      end else begin
         $display("FAIL motor_speed_ramp_generator_core");
      end
      $finish;
   end

   // Watchdog for a hung handshake.
   initial begin
      #3_000_000;
      $display("FAIL motor_speed_ramp_generator_core");
      $finish;
   end

endmodule
